// ===== design/psf_pkg.sv =====
// Shared types and constants for the PNG Sub-filter scanline block.
`default_nettype none
package psf_pkg;

    localparam int COL_W      = 16;   // column counter width
    localparam int SAMPLE_W   = 16;
    localparam int CH_MAX     = 4;
    localparam int DATA_MAX   = 8;    // data bytes per pixel at most
    localparam int NDATA_W    = 4;    // holds 1..DATA_MAX
    localparam int DIDX_W     = 3;    // indexes DATA_MAX entries
    localparam int POS_W      = 4;    // holds 0..DATA_MAX
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BPC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BGR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd3;

    localparam logic [1:0] BPC_WIDE = 2'd2;

    // Filter-type bytes.
    localparam logic [7:0] FILTER_NONE = 8'd0;
    localparam logic [7:0] FILTER_SUB  = 8'd1;

    typedef struct packed {
        logic [1:0]       bpc;
        logic [2:0]       chan;
        logic             bgr;
        logic [COL_W-1:0] width;
    } cfg_t;

    typedef logic [DATA_MAX-1:0][7:0] data_bytes_t;

    // One classified pixel: the data bytes in output order and the framing.
    typedef struct packed {
        data_bytes_t        bytes;
        logic [NDATA_W-1:0] n_data;
        logic               has_filter;
        logic               wide;
    } job_t;

endpackage
`default_nettype wire

// ===== design/psf_if.sv =====
// Handshake interfaces for the pixel input and the byte output channels.
`default_nettype none
interface psf_pix_if;
    logic                          valid;
    logic                          ready;
    logic [psf_pkg::SAMPLE_W-1:0]  sample0;
    logic [psf_pkg::SAMPLE_W-1:0]  sample1;
    logic [psf_pkg::SAMPLE_W-1:0]  sample2;
    logic [psf_pkg::SAMPLE_W-1:0]  sample3;

    modport source (output valid, sample0, sample1, sample2, sample3, input ready);
    modport sink   (input valid, sample0, sample1, sample2, sample3, output ready);
endinterface

interface psf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_filter_byte;
    logic       last;

    modport source (output valid, out_byte, is_filter_byte, last, input ready);
    modport sink   (input valid, out_byte, is_filter_byte, last, output ready);
endinterface
`default_nettype wire

// ===== design/psf_front.sv =====
// Front end: accepts pixels, applies the Sub filter or byte split, tracks the row.
`default_nettype none
module psf_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire psf_pkg::cfg_t  cfg,
    psf_pix_if.sink             pix_in,
    output logic                push_valid,
    input  wire logic           push_ready,
    output psf_pkg::job_t       push_data
);

    logic [31:0]                 prev_reg;
    logic [31:0]                 prev_next;
    logic [psf_pkg::COL_W-1:0]   col_reg;
    logic [psf_pkg::COL_W-1:0]   col_next;
    logic [psf_pkg::COL_W:0]     col_plus;
    logic                        accept;
    logic                        first;
    logic                        wide;
    logic                        bgr_eff;
    logic [2:0]                  nch;
    logic [3:0][7:0]             lo;
    logic [3:0][7:0]             hi;
    logic [3:0][7:0]             diff;

    assign accept     = pix_in.valid && pix_in.ready;
    assign pix_in.ready = push_ready;
    assign push_valid = pix_in.valid;

    assign first = (col_reg == '0);
    assign wide  = (cfg.bpc == psf_pkg::BPC_WIDE);

    always_comb
    begin
        if (cfg.chan == 3'd0)
        begin
            nch = 3'd1;
        end
        else if (cfg.chan > 3'(psf_pkg::CH_MAX))
        begin
            nch = 3'(psf_pkg::CH_MAX);
        end
        else
        begin
            nch = cfg.chan;
        end
    end

    assign bgr_eff = cfg.bgr && (nch >= 3'd3) && !wide;

    assign lo[0] = pix_in.sample0[7:0];
    assign lo[1] = pix_in.sample1[7:0];
    assign lo[2] = pix_in.sample2[7:0];
    assign lo[3] = pix_in.sample3[7:0];
    assign hi[0] = pix_in.sample0[15:8];
    assign hi[1] = pix_in.sample1[15:8];
    assign hi[2] = pix_in.sample2[15:8];
    assign hi[3] = pix_in.sample3[15:8];

    // The first pixel of a row subtracts zero.
    always_comb
    begin
        for (int c = 0; c < psf_pkg::CH_MAX; c++)
        begin
            diff[c] = lo[c] - (first ? 8'd0 : prev_reg[8*c +: 8]);
        end
    end

    always_comb
    begin
        push_data            = '0;
        push_data.has_filter = first;
        push_data.wide       = wide;
        if (wide)
        begin
            push_data.n_data = {nch, 1'b0};
            for (int c = 0; c < psf_pkg::CH_MAX; c++)
            begin
                push_data.bytes[2*c]   = hi[c];
                push_data.bytes[2*c+1] = lo[c];
            end
        end
        else
        begin
            push_data.n_data   = {1'b0, nch};
            push_data.bytes[0] = bgr_eff ? diff[2] : diff[0];
            push_data.bytes[1] = diff[1];
            push_data.bytes[2] = bgr_eff ? diff[0] : diff[2];
            push_data.bytes[3] = diff[3];
        end
    end

    assign prev_next = {lo[3], lo[2], lo[1], lo[0]};
    assign col_plus  = {1'b0, col_reg} + 1'b1;
    assign col_next  = (col_plus >= {1'b0, cfg.width}) ? '0 : col_plus[psf_pkg::COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            col_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg <= prev_next;
            col_reg  <= col_next;
        end
    end

`ifndef SYNTH
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (col_plus >= {1'b0, cfg.width}) |=> col_reg == '0)
        else $error("column count did not wrap at row end");

    a_job_len: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_data.n_data != '0) &&
                       (push_data.n_data <= 4'(psf_pkg::DATA_MAX)))
        else $error("job data length out of range");

    a_prev_store: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prev_reg == $past(prev_next))
        else $error("previous pixel not stored on accept");
`endif

endmodule
`default_nettype wire

// ===== design/psf_fifo.sv =====
// Two-entry job queue between the front end and the byte sequencer.
`default_nettype none
module psf_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire psf_pkg::job_t  push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output psf_pkg::job_t       pop_data
);

    psf_pkg::job_t                 mem [psf_pkg::QDEPTH];
    logic [psf_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [psf_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [psf_pkg::QCNT_W-1:0]    count_reg;
    logic [psf_pkg::QCNT_W-1:0]    count_next;
    logic                          push;
    logic                          pop;

    assign push_ready = (count_reg != psf_pkg::QCNT_W'(psf_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= psf_pkg::QCNT_W'(psf_pkg::QDEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == psf_pkg::QCNT_W'(psf_pkg::QDEPTH) || count_reg == '0)
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        push && pop |=> count_reg == $past(count_reg))
        else $error("queue count moved on simultaneous push and pop");
`endif

endmodule
`default_nettype wire

// ===== design/psf_back.sv =====
// Byte sequencer: walks each queued job and drives the registered byte output.
`default_nettype none
module psf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire psf_pkg::job_t  pop_data,
    psf_byte_if.source          byte_out
);

    logic [psf_pkg::POS_W-1:0]   pos_reg;
    logic [psf_pkg::POS_W-1:0]   pos_next;
    logic [psf_pkg::POS_W-1:0]   n_total;
    logic [psf_pkg::POS_W-1:0]   data_idx;
    logic                        adv;
    logic                        last_now;
    logic                        filt_now;
    logic [7:0]                  byte_now;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  out_byte_reg;
    logic                        out_filt_reg;
    logic                        out_last_reg;

    assign n_total  = pop_data.n_data + psf_pkg::POS_W'(pop_data.has_filter);
    assign data_idx = pos_reg - psf_pkg::POS_W'(pop_data.has_filter);
    assign filt_now = pop_data.has_filter && (pos_reg == '0);
    assign last_now = (pos_reg == n_total - 1'b1);

    always_comb
    begin
        if (filt_now)
        begin
            byte_now = pop_data.wide ? psf_pkg::FILTER_NONE : psf_pkg::FILTER_SUB;
        end
        else
        begin
            byte_now = pop_data.bytes[data_idx[psf_pkg::DIDX_W-1:0]];
        end
    end

    // A waiting job refills the output register whenever it is empty or being drained.
    assign adv       = pop_valid && (!out_valid_reg || byte_out.ready);
    assign pop_ready = adv && last_now;

    always_comb
    begin
        pos_next = pos_reg;
        if (adv)
        begin
            pos_next = last_now ? '0 : pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (byte_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= byte_now;
            out_filt_reg <= filt_now;
            out_last_reg <= last_now;
        end
    end

    assign byte_out.valid          = out_valid_reg;
    assign byte_out.out_byte       = out_byte_reg;
    assign byte_out.is_filter_byte = out_filt_reg;
    assign byte_out.last           = out_last_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> pos_reg < n_total)
        else $error("byte position beyond job length");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pop_valid |-> pos_reg == '0)
        else $error("byte position nonzero with no job");

    a_filter_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        adv && filt_now |-> !last_now)
        else $error("filter byte marked as last of a pixel");
`endif

endmodule
`default_nettype wire

// ===== design/png_scanline_sub_filter.sv =====
// Top level of the PNG scanline generator with Sub filtering and 16-bit byte split.
//
// Each accepted pixel produces its PNG scanline bytes on byte_out, one byte per
// cycle unless byte_out.ready stalls it: a filter-type byte when the pixel opens
// a row, then one byte per channel in 8-bit mode or two bytes per channel (high
// byte first) in 16-bit mode, so a pixel yields 1 to 9 bytes and the sustained
// rate is set by that one-byte-per-cycle output register. Pixels are taken on
// back-to-back cycles while the two-entry job queue between the filter front end
// and the byte sequencer has room; the first byte of a pixel passes through the
// job queue and then the output register before it is presented on byte_out.
// Configuration is taken at any time but should be written only while no
// pixel is in flight.
`default_nettype none
module png_scanline_sub_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [psf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [psf_pkg::CFG_DATA_W-1:0]    cfg_data,
    psf_pix_if.sink                                pix_in,
    psf_byte_if.source                             byte_out
);

    psf_pkg::cfg_t  cfg_reg;
    logic           push_valid;
    logic           push_ready;
    psf_pkg::job_t  push_data;
    logic           pop_valid;
    logic           pop_ready;
    psf_pkg::job_t  pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bpc   <= 2'd1;
            cfg_reg.chan  <= 3'd1;
            cfg_reg.bgr   <= 1'b0;
            cfg_reg.width <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psf_pkg::REG_BPC:   cfg_reg.bpc   <= cfg_data[1:0];
                psf_pkg::REG_CHAN:  cfg_reg.chan  <= cfg_data[2:0];
                psf_pkg::REG_BGR:   cfg_reg.bgr   <= cfg_data[0];
                psf_pkg::REG_WIDTH: cfg_reg.width <= cfg_data[psf_pkg::COL_W-1:0];
                default:            cfg_reg       <= cfg_reg;
            endcase
        end
    end

    psf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pix_in     (pix_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    psf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    psf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .byte_out   (byte_out)
    );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for png_scanline_sub_filter: directed table, then random pixels.
`timescale 1ns / 100ps
module testbench;
    import psf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_PIXELS = 50;
    localparam int DIR_N        = 37;

    typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

    // A pixel row carries sample3..sample0 from left to right; typed bytes are
    // listed in output order from the left.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        logic [63:0]           smp;
        logic [1:0]            n_typed;
        logic [23:0]           typed;
    } plan_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       filt;
        logic       last;
    } scan_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    psf_pix_if  pix ();
    psf_byte_if byte_ch ();

    png_scanline_sub_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix),
        .byte_out  (byte_ch)
    );

    // Shadow of the block's registers and state.
    cfg_t             mode;
    logic [31:0]      last_pix;
    logic [COL_W-1:0] col_pos;

    scan_byte_t  pending_bytes [$];
    int unsigned mismatches;
    int unsigned cycle_count = 0;
    int unsigned idle_pct;
    int unsigned stall_pct;

    plan_row_t dir_tab [DIR_N] = '{
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h1111_2222_3333_FFFF, 2'd2, 24'h01FF00},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'hFFFF_FFFF_FFFF_0000, 2'd2, 24'h010000},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_0000_1234, 2'd2, 24'h013400},
        '{ROW_CFG,   REG_BPC,   16'hFFFE,   64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_0000_A55A, 2'd3, 24'h00A55A},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 24'h00FFFF},
        '{ROW_CFG,   REG_CHAN,  16'd4,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_BGR,   16'd1,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_WIDTH, 16'd3,      64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0123_4567_89AB_CDEF, 2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'hFFFF_0000_FFFF_0000, 2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h8001_7FFE_00FF_FF00, 2'd0, 24'h0},
        '{ROW_CFG,   REG_BPC,   16'd1,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_CHAN,  16'd3,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_WIDTH, 16'd4,      64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0011_0022_0033, 2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_00FF_0000_0010, 2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_00FF_0005, 2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 24'h0},
        '{ROW_CFG,   REG_CHAN,  16'd0,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_WIDTH, 16'd0,      64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_0000_00AB, 2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_0000_00CD, 2'd0, 24'h0},
        '{ROW_CFG,   REG_CHAN,  16'd7,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_BPC,   16'd3,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_BGR,   16'd0,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_WIDTH, 16'd5,      64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h1020_3040_5060_7080, 2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0F0F_F0F0_AAAA_5555, 2'd0, 24'h0},
        '{ROW_CFG,   REG_BPC,   16'd0,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_CHAN,  16'd2,      64'h0,                   2'd0, 24'h0},
        '{ROW_CFG,   REG_BGR,   16'd1,      64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_00C0_00B0, 2'd0, 24'h0},
        '{ROW_CFG,   REG_BPC,   16'd2,      64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_1234_5678, 2'd0, 24'h0},
        '{ROW_CFG,   REG_BPC,   16'd1,      64'h0,                   2'd0, 24'h0},
        '{ROW_PIXEL, REG_BPC,   16'd0,      64'h0000_0000_0001_0002, 2'd0, 24'h0}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    task automatic report(input string msg);
        $display("testbench: cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Works out the scanline bytes of one pixel and advances the shadow state.
    function automatic void predict_pixel(input logic [3:0][15:0] smp, input bit keep);
        scan_byte_t  seq [$];
        int          nch;
        int          src;
        bit          wide;
        bit          opens;
        logic [31:0] cur;
        logic [7:0]  prev;
        wide  = (mode.bpc == BPC_WIDE);
        opens = (col_pos == '0);
        nch   = (mode.chan == 3'd0) ? 1 : (mode.chan > 3'd4) ? 4 : int'(mode.chan);
        for (int c = 0; c < 4; c++)
            cur[8*c +: 8] = smp[c][7:0];
        if (opens)
            seq.insert(seq.size(),
                       scan_byte_t'{wide ? FILTER_NONE : FILTER_SUB, 1'b1, 1'b0});
        for (int c = 0; c < nch; c++)
        begin
            if (wide)
            begin
                seq.insert(seq.size(), scan_byte_t'{smp[c][15:8], 1'b0, 1'b0});
                seq.insert(seq.size(), scan_byte_t'{smp[c][7:0], 1'b0, 1'b0});
            end
            else
            begin
                // Swapping applies to channels 0 and 2 only; channel 3 stays put.
                src  = (mode.bgr && nch >= 3 && c != 3) ? 2 - c : c;
                prev = opens ? 8'd0 : last_pix[8*src +: 8];
                seq.insert(seq.size(),
                           scan_byte_t'{8'(smp[src][7:0] - prev), 1'b0, 1'b0});
            end
        end
        seq[seq.size()-1].last = 1'b1;
        last_pix = cur;
        if ({1'b0, col_pos} + 17'd1 >= {1'b0, mode.width})
            col_pos = '0;
        else
            col_pos = col_pos + 1'b1;
        if (keep)
            foreach (seq[k])
                pending_bytes.insert(pending_bytes.size(), seq[k]);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_BPC:   mode.bpc   = value[1:0];
            REG_CHAN:  mode.chan  = value[2:0];
            REG_BGR:   mode.bgr   = value[0];
            REG_WIDTH: mode.width = value[COL_W-1:0];
            default:   ;
        endcase
    endtask

    // Lets every outstanding byte come out, then waits out DRAIN_CYCLES.
    task automatic settle();
        pix.valid <= 1'b0;
        cfg_we    <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(input logic [3:0][15:0] smp, input int n_typed,
                              input logic [23:0] typed);
        while ($urandom_range(99) < idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid   <= 1'b1;
        pix.sample0 <= smp[0];
        pix.sample1 <= smp[1];
        pix.sample2 <= smp[2];
        pix.sample3 <= smp[3];
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        predict_pixel(smp, n_typed == 0);
        for (int k = 0; k < n_typed; k++)
            pending_bytes.insert(pending_bytes.size(),
                                 scan_byte_t'{typed[23-8*k -: 8], k == 0, k == n_typed - 1});
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic check_byte();
        scan_byte_t want;
        if (pending_bytes.size() == 0)
            report($sformatf("unexpected beat, byte %02h", byte_ch.out_byte));
        else
        begin
            want = pending_bytes.pop_front();
            if (byte_ch.out_byte !== want.data)
                report($sformatf("out_byte %02h, want %02h", byte_ch.out_byte, want.data));
            if (byte_ch.is_filter_byte !== want.filt)
                report($sformatf("is_filter_byte %b, want %b", byte_ch.is_filter_byte, want.filt));
            if (byte_ch.last !== want.last)
                report($sformatf("last %b, want %b", byte_ch.last, want.last));
        end
    endtask

    // Output side: checks each beat, then decides whether to stall the next cycle.
    initial
    begin
        byte_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
                check_byte();
            byte_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        logic [15:0] width_val;
        mismatches  = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        mode        = '{bpc: 2'd1, chan: 3'd1, bgr: 1'b0, width: 16'd1};
        last_pix    = '0;
        col_pos     = '0;
        rst_n       = 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_BPC;
        cfg_data    <= '0;
        pix.valid   <= 1'b0;
        pix.sample0 <= '0;
        pix.sample1 <= '0;
        pix.sample2 <= '0;
        pix.sample3 <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_N; r++)
        begin
            if (dir_tab[r].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_tab[r].idx, dir_tab[r].value);
            end
            else
            begin
                cfg_we <= 1'b0;
                send_pixel(dir_tab[r].smp, dir_tab[r].n_typed, dir_tab[r].typed);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 53; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 6;  stall_pct = 6;  end
            endcase
            case (ph)
                0:       width_val = 16'hFFFF;
                1:       width_val = 16'd0;
                5:       width_val = 16'($urandom_range(65535));
                default: width_val = 16'($urandom_range(1, 6));
            endcase
            settle();
            // Upper bits of the narrow registers carry junk that must be dropped.
            write_reg(REG_BPC, {14'($urandom),
                                (ph % 3 == 0) ? BPC_WIDE : 2'($urandom_range(3))});
            write_reg(REG_CHAN, {13'($urandom), 3'($urandom_range(7))});
            write_reg(REG_BGR, {15'($urandom), 1'($urandom_range(1))});
            write_reg(REG_WIDTH, width_val);
            cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel({pick_sample(), pick_sample(), pick_sample(), pick_sample()},
                           0, '0);
        end

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
